// ===== hdl/vrlfs_pkg.sv =====
// Package for the video rate limiter / frame sizer.
// Holds controller states, datapath op codes, status struct and constants.
// No dependencies.
package vrlfs_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IFR   = 3'd5;

    localparam logic [31:0] BPS_RST   = 32'd21474836;
    localparam logic [15:0] MUR_RST   = 16'd6554;
    localparam logic [15:0] HOLD_RST  = 16'd3;
    localparam logic [19:0] BIG_RST   = 20'd32768;
    localparam logic [7:0]  BLEN_RST  = 8'd10;
    localparam logic [19:0] IFR_RST   = 20'd262144;

    localparam logic [31:0] MIN_RATE    = 32'd100;
    localparam logic [19:0] RATIO_FLOOR = 20'd13107;
    localparam logic [16:0] Q16_ONE     = 17'h10000;
    localparam logic [23:0] BYTES_MAX   = 24'hFFFFFF;
    localparam logic [4:0]  DIV_LAST    = 5'd23;

    typedef enum logic [3:0] {
        S_IDLE, S_UBIG, S_UUP, S_UDN, S_UFIN,
        S_TRS, S_TSIZE, S_TDIV, S_TRATIO,
        S_MHI, S_MLO, S_MSUM, S_TNOISE, S_TFIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MBIG, OP_MUP, OP_MDN, OP_UFIN,
        OP_MRS, OP_TSIZE, OP_DIV, OP_RATIO,
        OP_MHI, OP_MLO, OP_MSUM, OP_NOISE, OP_TFIN
    } t_op;

    typedef struct packed {
        logic out_free;
        logic burst_nz;
        logic burst_first;
        logic div_need;
        logic div_last;
        logic fac_pos;
    } t_dp_sts;

endpackage

// ===== hdl/vrlfs_ctrl.sv =====
// Controller state machine of the frame sizer.
// Sequences the shared multiplier and divider through op codes.
// Depends on vrlfs_pkg.
module vrlfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd,
    input  vrlfs_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output vrlfs_pkg::t_op    o_op
);

    vrlfs_pkg::t_state r_state, n_state;
    logic              r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrlfs_pkg::S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        case (r_state)
            vrlfs_pkg::S_IDLE: begin
                n_pass = 1'b0;
                if (i_in_valid) n_state = i_cmd ? vrlfs_pkg::S_UBIG : vrlfs_pkg::S_TRS;
            end
            vrlfs_pkg::S_UBIG:   n_state = vrlfs_pkg::S_UUP;
            vrlfs_pkg::S_UUP:    n_state = vrlfs_pkg::S_UDN;
            vrlfs_pkg::S_UDN:    n_state = vrlfs_pkg::S_UFIN;
            vrlfs_pkg::S_UFIN:   if (i_sts.out_free) n_state = vrlfs_pkg::S_IDLE;
            vrlfs_pkg::S_TRS:    n_state = vrlfs_pkg::S_TSIZE;
            vrlfs_pkg::S_TSIZE: begin
                if (!i_sts.burst_nz)      n_state = vrlfs_pkg::S_TNOISE;
                else if (i_sts.burst_first) n_state = vrlfs_pkg::S_MHI;
                else if (i_sts.div_need)  n_state = vrlfs_pkg::S_TDIV;
                else                      n_state = vrlfs_pkg::S_MHI;
            end
            vrlfs_pkg::S_TDIV:   if (i_sts.div_last) n_state = vrlfs_pkg::S_TRATIO;
            vrlfs_pkg::S_TRATIO: n_state = vrlfs_pkg::S_MHI;
            vrlfs_pkg::S_MHI:    n_state = vrlfs_pkg::S_MLO;
            vrlfs_pkg::S_MLO:    n_state = vrlfs_pkg::S_MSUM;
            vrlfs_pkg::S_MSUM:   n_state = r_pass ? vrlfs_pkg::S_TFIN : vrlfs_pkg::S_TNOISE;
            vrlfs_pkg::S_TNOISE: begin
                n_pass  = 1'b1;
                n_state = i_sts.fac_pos ? vrlfs_pkg::S_MHI : vrlfs_pkg::S_TFIN;
            end
            vrlfs_pkg::S_TFIN:   if (i_sts.out_free) n_state = vrlfs_pkg::S_IDLE;
            default:             n_state = vrlfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = vrlfs_pkg::OP_NONE;
        case (r_state)
            vrlfs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = vrlfs_pkg::OP_LOAD;
            end
            vrlfs_pkg::S_UBIG:   o_op = vrlfs_pkg::OP_MBIG;
            vrlfs_pkg::S_UUP:    o_op = vrlfs_pkg::OP_MUP;
            vrlfs_pkg::S_UDN:    o_op = vrlfs_pkg::OP_MDN;
            vrlfs_pkg::S_UFIN:   if (i_sts.out_free) o_op = vrlfs_pkg::OP_UFIN;
            vrlfs_pkg::S_TRS:    o_op = vrlfs_pkg::OP_MRS;
            vrlfs_pkg::S_TSIZE:  o_op = vrlfs_pkg::OP_TSIZE;
            vrlfs_pkg::S_TDIV:   o_op = vrlfs_pkg::OP_DIV;
            vrlfs_pkg::S_TRATIO: o_op = vrlfs_pkg::OP_RATIO;
            vrlfs_pkg::S_MHI:    o_op = vrlfs_pkg::OP_MHI;
            vrlfs_pkg::S_MLO:    o_op = vrlfs_pkg::OP_MLO;
            vrlfs_pkg::S_MSUM:   o_op = vrlfs_pkg::OP_MSUM;
            vrlfs_pkg::S_TNOISE: o_op = vrlfs_pkg::OP_NOISE;
            vrlfs_pkg::S_TFIN:   if (i_sts.out_free) o_op = vrlfs_pkg::OP_TFIN;
            default:             o_op = vrlfs_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== hdl/vrlfs_dp.sv =====
// Datapath of the frame sizer: config registers, rate state, shared
// 32x32 multiplier, radix-2 divider and the output register.
// Depends on vrlfs_pkg.
module vrlfs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vrlfs_pkg::t_op                  i_op,
    output vrlfs_pkg::t_dp_sts              o_sts,
    input  logic                            i_cfg_wr,
    input  logic [vrlfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic [31:0]                     i_proposed_rate,
    input  logic signed [17:0]              i_noise_fraction,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [31:0]                     o_current_rate,
    output logic [23:0]                     o_frame_bytes,
    output logic                            o_is_iframe,
    output logic                            o_update_accepted,
    output logic                            o_burst_restarted
);

    logic [31:0] r_bps;
    logic [15:0] r_mur;
    logic [15:0] r_hold_cfg;
    logic [19:0] r_big_cfg;
    logic [7:0]  r_blen;
    logic [19:0] r_ifr;

    logic [31:0] r_rate;
    logic [15:0] r_hold;
    logic [7:0]  r_burst;

    logic [31:0] r_p;
    logic [17:0] r_noise;
    logic [63:0] r_prod;
    logic        r_big;
    logic [48:0] r_up;
    logic [47:0] r_size;
    logic [19:0] r_ratio;
    logic [51:0] r_hi;
    logic [7:0]  r_rem;
    logic [23:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_iframe;

    logic        r_ovalid;
    logic [31:0] r_orate;
    logic [23:0] r_obytes;
    logic        r_oif;
    logic        r_oacc;
    logic        r_orst;

    logic [31:0] mul_a, mul_b;
    logic        mul_en;
    logic [31:0] diff;
    logic [16:0] fup, fdn;
    logic [47:0] pq;
    logic        rej;
    logic [31:0] n_rate;
    logic [31:0] dn_rate;
    logic [24:0] num;
    logic [8:0]  trial, dv;
    logic        ge;
    logic [52:0] sum;
    logic [18:0] fac;
    logic [31:0] by;
    logic [23:0] n_bytes;

    assign diff = (r_p >= r_rate) ? (r_p - r_rate) : (r_rate - r_p);
    assign fup  = vrlfs_pkg::Q16_ONE + {1'b0, r_mur};
    assign fdn  = vrlfs_pkg::Q16_ONE - {1'b0, r_mur};
    assign pq   = {r_p, 16'h0000};
    assign rej  = (r_p == 32'd0) || (r_hold != 16'd0);
    assign dn_rate = r_prod[47:16];

    always_comb begin
        n_rate = r_rate;
        if (!rej) begin
            if (r_big || (r_mur == 16'd0)) begin
                n_rate = r_p;
            end else if ({1'b0, pq} > r_up) begin
                n_rate = (r_up[48] == 1'b1) ? 32'hFFFF_FFFF : r_up[47:16];
            end else if ({1'b0, pq} < r_prod[48:0]) begin
                n_rate = (dn_rate < vrlfs_pkg::MIN_RATE) ? vrlfs_pkg::MIN_RATE : dn_rate;
            end else begin
                n_rate = r_p;
            end
        end
    end

    always_comb begin
        mul_en = 1'b1;
        mul_a  = r_rate;
        mul_b  = 32'd0;
        case (i_op)
            vrlfs_pkg::OP_MBIG: mul_b = {12'd0, r_big_cfg};
            vrlfs_pkg::OP_MUP:  mul_b = {15'd0, fup};
            vrlfs_pkg::OP_MDN:  mul_b = {15'd0, fdn};
            vrlfs_pkg::OP_MRS:  mul_b = r_bps;
            vrlfs_pkg::OP_MHI: begin
                mul_a = r_size[47:16];
                mul_b = {12'd0, r_ratio};
            end
            vrlfs_pkg::OP_MLO: begin
                mul_a = {16'd0, r_size[15:0]};
                mul_b = {12'd0, r_ratio};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign num   = {1'b0, r_blen, 16'h0000} - {5'd0, r_ifr};
    assign dv    = {1'b0, r_blen - 8'd1};
    assign trial = {r_rem, r_quo[23]};
    assign ge    = (trial >= dv);
    assign sum   = {1'b0, r_hi} + {33'd0, r_prod[35:16]};
    assign fac   = 19'h10000 + {r_noise[17], r_noise};
    assign by    = r_size[47:16];
    assign n_bytes = (by == 32'd0) ? 24'd1 :
                     ((by[31:24] != 8'd0) ? vrlfs_pkg::BYTES_MAX : by[23:0]);

    assign o_sts.out_free    = !r_ovalid || i_out_ready;
    assign o_sts.burst_nz    = (r_burst != 8'd0);
    assign o_sts.burst_first = (r_burst == r_blen);
    assign o_sts.div_need    = (r_blen > 8'd1) && !num[24] && (num != 25'd0);
    assign o_sts.div_last    = (r_cnt == vrlfs_pkg::DIV_LAST);
    assign o_sts.fac_pos     = !fac[18] && (fac != 19'd0);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps      <= vrlfs_pkg::BPS_RST;
            r_mur      <= vrlfs_pkg::MUR_RST;
            r_hold_cfg <= vrlfs_pkg::HOLD_RST;
            r_big_cfg  <= vrlfs_pkg::BIG_RST;
            r_blen     <= vrlfs_pkg::BLEN_RST;
            r_ifr      <= vrlfs_pkg::IFR_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                vrlfs_pkg::CFG_BPS:  r_bps      <= i_cfg_data;
                vrlfs_pkg::CFG_MUR:  r_mur      <= i_cfg_data[15:0];
                vrlfs_pkg::CFG_HOLD: r_hold_cfg <= i_cfg_data[15:0];
                vrlfs_pkg::CFG_BIG:  r_big_cfg  <= i_cfg_data[19:0];
                vrlfs_pkg::CFG_BLEN: r_blen     <= i_cfg_data[7:0];
                vrlfs_pkg::CFG_IFR:  r_ifr      <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // rate state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= vrlfs_pkg::MIN_RATE;
            r_hold   <= 16'd0;
            r_burst  <= vrlfs_pkg::BLEN_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= ((i_op == vrlfs_pkg::OP_UFIN) || (i_op == vrlfs_pkg::OP_TFIN)) ?
                        1'b1 : (r_ovalid && !i_out_ready);
            case (i_op)
                vrlfs_pkg::OP_UFIN: begin
                    r_rate   <= n_rate;
                    if (!rej) begin
                        r_hold <= r_hold_cfg;
                        if (r_big) r_burst <= r_blen;
                    end
                end
                vrlfs_pkg::OP_TSIZE: if (r_burst != 8'd0) r_burst <= r_burst - 8'd1;
                vrlfs_pkg::OP_TFIN: begin
                    if (r_hold != 16'd0) r_hold <= r_hold - 16'd1;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_a * mul_b;
        case (i_op)
            vrlfs_pkg::OP_LOAD: begin
                r_p      <= i_proposed_rate;
                r_noise  <= i_noise_fraction;
                r_iframe <= 1'b0;
            end
            vrlfs_pkg::OP_MUP: r_big <= {4'd0, diff, 16'h0000} > r_prod[51:0];
            vrlfs_pkg::OP_MDN: r_up  <= r_prod[48:0];
            vrlfs_pkg::OP_TSIZE: begin
                r_size   <= r_prod[63:16];
                r_iframe <= (r_burst != 8'd0) && (r_burst == r_blen);
                r_ratio  <= (r_burst == r_blen) ? r_ifr : vrlfs_pkg::RATIO_FLOOR;
                r_quo    <= num[23:0];
                r_rem    <= 8'd0;
                r_cnt    <= 5'd0;
            end
            vrlfs_pkg::OP_DIV: begin
                r_rem <= ge ? 8'(trial - dv) : trial[7:0];
                r_quo <= {r_quo[22:0], ge};
                r_cnt <= r_cnt + 5'd1;
            end
            vrlfs_pkg::OP_RATIO:
                r_ratio <= (r_quo > {4'd0, vrlfs_pkg::RATIO_FLOOR}) ? r_quo[19:0]
                                                                   : vrlfs_pkg::RATIO_FLOOR;
            vrlfs_pkg::OP_MLO:  r_hi <= r_prod[51:0];
            vrlfs_pkg::OP_MSUM: r_size <= (sum[52:48] != 5'd0) ? {48{1'b1}} : sum[47:0];
            vrlfs_pkg::OP_NOISE: begin
                if (!fac[18] && (fac != 19'd0)) r_ratio <= {2'd0, fac[17:0]};
                else                            r_size  <= 48'd0;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        case (i_op)
            vrlfs_pkg::OP_UFIN: begin
                r_orate  <= n_rate;
                r_obytes <= 24'd0;
                r_oif    <= 1'b0;
                r_oacc   <= !rej;
                r_orst   <= !rej && r_big;
            end
            vrlfs_pkg::OP_TFIN: begin
                r_orate  <= r_rate;
                r_obytes <= n_bytes;
                r_oif    <= r_iframe;
                r_oacc   <= 1'b0;
                r_orst   <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_ovalid;
    assign o_current_rate    = r_orate;
    assign o_frame_bytes     = r_obytes;
    assign o_is_iframe       = r_oif;
    assign o_update_accepted = r_oacc;
    assign o_burst_restarted = r_orst;

endmodule

// ===== hdl/video_rate_limiter_frame_sizer.sv =====
// Top level of the video rate limiter / frame sizer.
// Instantiates vrlfs_ctrl and vrlfs_dp; uses vrlfs_pkg.
//
// Input channel (i_in_valid/o_in_ready) carries one item: i_cmd selects a
// frame tick (0) or a rate update proposal (1). Output channel
// (o_out_valid/i_out_ready) returns exactly one result item per input item.
// Config registers are written through i_cfg_wr/i_cfg_idx/i_cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce; unknown indexes are ignored. An update steps through
// S_UBIG, S_UUP, S_UDN and S_UFIN. A tick steps through S_TRS and S_TSIZE,
// on a later burst frame through the 24-step radix-2 divider that forms the
// burst ratio, and through the split 48x20 multiply (S_MHI, S_MLO, S_MSUM)
// on the shared 32x32 multiplier, done once per scaling.
// One item is worked on at a time; the next item is taken as soon as the
// result sits in the output register, even if not yet taken.
// Reset (synchronous, active low) loads the register defaults, rate 100,
// hold-off 0 and burst counter 10. A stalled receiver holds the result in
// the output register; the block then finishes the next item and waits.
module video_rate_limiter_frame_sizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [31:0]                     i_proposed_rate,
    input  logic signed [17:0]              i_noise_fraction,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [31:0]                     o_current_rate,
    output logic [23:0]                     o_frame_bytes,
    output logic                            o_is_iframe,
    output logic                            o_update_accepted,
    output logic                            o_burst_restarted,
    input  logic                            i_cfg_wr,
    input  logic [vrlfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);

    vrlfs_pkg::t_op     op;
    vrlfs_pkg::t_dp_sts sts;

    vrlfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_op       (op)
    );

    vrlfs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .o_sts             (sts),
        .i_cfg_wr          (i_cfg_wr),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_proposed_rate   (i_proposed_rate),
        .i_noise_fraction  (i_noise_fraction),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_current_rate    (o_current_rate),
        .o_frame_bytes     (o_frame_bytes),
        .o_is_iframe       (o_is_iframe),
        .o_update_accepted (o_update_accepted),
        .o_burst_restarted (o_burst_restarted)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while busy");

    a_update_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_update_accepted || o_burst_restarted)) |->
        (o_frame_bytes == 24'd0 && !o_is_iframe))
        else $error("update result carries frame fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_current_rate) && $stable(o_frame_bytes)))
        else $error("result changed while stalled");

    a_restart_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_burst_restarted) |-> o_update_accepted)
        else $error("restart without accepted update");
`endif

endmodule
